// ===== sv/descending_k_way_merge_dedup_macros.svh =====
// Assertion macros shared by the merge block's RTL files.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef DESCENDING_K_WAY_MERGE_DEDUP_MACROS_SVH
`define DESCENDING_K_WAY_MERGE_DEDUP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DKM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("merge block check failed");

// The consequent must hold in the cycle after the antecedent.
`define DKM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("merge block check failed");

`endif

// ===== sv/dkm_pkg.sv =====
// Shared constants, codes and types of the descending merge block.
// Used by dkm_best and the top module; depends on nothing.
`default_nettype none

package dkm_pkg;

  localparam int LANES      = 8;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CNT_W  = $clog2(LANES + 1);
  localparam int HEAD_W = KEY_BITS + VALUE_BITS;

  localparam int KIND_W   = 2;
  localparam int LANE_IN_W = 3;
  localparam int FIELD_W  = 32;
  localparam int STATUS_W = 2;
  localparam int MASK_W   = 8;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd2;

  // Per-lane status.
  localparam logic [1:0] LS_REFILL = 2'd0;
  localparam logic [1:0] LS_HOLD   = 2'd1;
  localparam logic [1:0] LS_DONE   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_RECORD    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WAITING   = 2'd2;

  typedef struct packed {
    logic              clear;
    logic              step;
    logic [LANE_W-1:0] lane;
  } best_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/dkm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the lane head records of the merge block.
`default_nettype none

module dkm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/dkm_best.sv =====
// Shared compare unit: folds one head record per step into the running
// largest key, its value and the mask of lanes holding it. Uses dkm_pkg.
`default_nettype none

module dkm_best import dkm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire best_ctrl_t            ctrl_i,
  input  wire logic [KEY_BITS-1:0]   cand_key_i,
  input  wire logic [VALUE_BITS-1:0] cand_value_i,
  output logic      [KEY_BITS-1:0]   best_key_o,
  output logic      [VALUE_BITS-1:0] best_value_o,
  output logic      [LANES-1:0]      match_mask_o
);

  `include "descending_k_way_merge_dedup_macros.svh"

  logic                  found_q, found_d;
  logic [KEY_BITS-1:0]   best_key_q, best_key_d;
  logic [VALUE_BITS-1:0] best_value_q, best_value_d;
  logic [LANES-1:0]      match_mask_q, match_mask_d;
  logic [LANES-1:0]      lane_bit;
  logic                  greater;
  logic                  equal;

  always_comb begin
    lane_bit = '0;
    lane_bit[ctrl_i.lane] = 1'b1;
  end

  assign greater = !found_q || (cand_key_i > best_key_q);
  assign equal   = cand_key_i == best_key_q;

  always_comb begin
    found_d      = found_q;
    best_key_d   = best_key_q;
    best_value_d = best_value_q;
    match_mask_d = match_mask_q;
    priority if (ctrl_i.clear) begin
      found_d = 1'b0;
    end else if (ctrl_i.step && greater) begin
      found_d      = 1'b1;
      best_key_d   = cand_key_i;
      best_value_d = cand_value_i;
      match_mask_d = lane_bit;
    end else if (ctrl_i.step && equal) begin
      // Lanes come in ascending order, so a tie hands over to the later lane.
      best_value_d = cand_value_i;
      match_mask_d = match_mask_q | lane_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_key_q   <= best_key_d;
    best_value_q <= best_value_d;
    match_mask_q <= match_mask_d;
  end

  assign best_key_o   = best_key_q;
  assign best_value_o = best_value_q;
  assign match_mask_o = match_mask_q;

  `DKM_ASSERT_SAME(a_found_has_lane, found_q, match_mask_q != '0)
  `DKM_ASSERT_NEXT(a_clear_drops_found, ctrl_i.clear, !found_q)

endmodule

`default_nettype wire

// ===== sv/descending_k_way_merge_dedup.sv =====
// Channel | direction | fields                                  | handshake
// in      | input     | kind, lane, new_key, new_value          | in_valid_i / in_stall_o
// out     | output    | status, out_key, out_value, refill_mask | out_valid_o / out_stall_i
//
// Deliver and end items keep the block idle, so it can accept the next item straight away.
// A request that finds every lane holding or ended, and at least one holding, scans
// the head RAM with one comparator, one lane per cycle.
// A request answered with exhausted or waiting skips the scan and goes straight to the emit state.
// Reset sets every lane to need a refill; head records are unknown until delivered.
// A stalled result waits in the output register; deliver and end items are
// still accepted meanwhile, and a request finishes once the register frees up.
`default_nettype none

module descending_k_way_merge_dedup import dkm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [KIND_W-1:0]    kind_i,
  input  wire logic [LANE_IN_W-1:0] lane_i,
  input  wire logic [FIELD_W-1:0]   new_key_i,
  input  wire logic [FIELD_W-1:0]   new_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [STATUS_W-1:0]  status_o,
  output logic      [FIELD_W-1:0]   out_key_o,
  output logic      [FIELD_W-1:0]   out_value_o,
  output logic      [MASK_W-1:0]    refill_mask_o
);

  `include "descending_k_way_merge_dedup_macros.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [1:0]          lane_q [LANES];
  logic [1:0]          lane_d [LANES];
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [LANES-1:0]    hold_q, hold_d;
  logic                rd_vld_q, rd_vld_d;
  logic                rd_hold_q, rd_hold_d;
  logic [LANE_W-1:0]   rd_lane_q, rd_lane_d;
  logic [STATUS_W-1:0] pend_status_q, pend_status_d;
  logic [LANES-1:0]    pend_mask_q, pend_mask_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [KEY_BITS-1:0] out_key_q, out_key_d;
  logic [VALUE_BITS-1:0] out_value_q, out_value_d;
  logic [LANES-1:0]    out_mask_q, out_mask_d;

  logic                in_acc;
  logic                out_free;
  logic                lane_ok;
  logic [LANE_W-1:0]   lane_idx;
  logic                lane_refill;
  logic                wr_head;
  logic [LANES-1:0]    hold_vec;
  logic [LANES-1:0]    done_vec;
  logic [LANES-1:0]    wait_vec;
  logic                scan_issue;
  logic                scan_end;
  logic [HEAD_W-1:0]   head_rdata;
  best_ctrl_t          best_ctrl;
  logic [KEY_BITS-1:0] best_key;
  logic [VALUE_BITS-1:0] best_value;
  logic [LANES-1:0]    best_mask;

  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign lane_ok     = int'(lane_i) < LANES;
  assign lane_idx    = LANE_W'(lane_i);
  assign lane_refill = lane_ok && (lane_q[lane_idx] == LS_REFILL);
  assign wr_head     = in_acc && (kind_i == KIND_DELIVER) && lane_refill;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      hold_vec[i] = lane_q[i] == LS_HOLD;
      done_vec[i] = lane_q[i] == LS_DONE;
      wait_vec[i] = lane_q[i] == LS_REFILL;
    end
  end

  assign scan_issue = (state_q == S_SCAN) && (int'(cnt_q) < LANES);
  assign scan_end   = (state_q == S_SCAN) && !scan_issue && !rd_vld_q;

  dkm_ram #(
    .WIDTH(HEAD_W),
    .DEPTH(LANES)
  ) u_head_ram (
    .clk_i  (clk_i),
    .we_i   (wr_head),
    .waddr_i(lane_idx),
    .wdata_i({KEY_BITS'(new_key_i), VALUE_BITS'(new_value_i)}),
    .re_i   (scan_issue),
    .raddr_i(cnt_q[LANE_W-1:0]),
    .rdata_o(head_rdata)
  );

  always_comb begin
    best_ctrl.clear = in_acc && (kind_i == KIND_REQUEST);
    best_ctrl.step  = rd_vld_q && rd_hold_q;
    best_ctrl.lane  = rd_lane_q;
  end

  dkm_best u_best (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (best_ctrl),
    .cand_key_i  (head_rdata[HEAD_W-1:VALUE_BITS]),
    .cand_value_i(head_rdata[VALUE_BITS-1:0]),
    .best_key_o  (best_key),
    .best_value_o(best_value),
    .match_mask_o(best_mask)
  );

  always_comb begin
    state_d       = state_q;
    lane_d        = lane_q;
    cnt_d         = cnt_q;
    hold_d        = hold_q;
    rd_vld_d      = scan_issue;
    rd_hold_d     = hold_q[0];
    rd_lane_d     = cnt_q[LANE_W-1:0];
    pend_status_d = pend_status_q;
    pend_mask_d   = pend_mask_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_status_d  = out_status_q;
    out_key_d     = out_key_q;
    out_value_d   = out_value_q;
    out_mask_d    = out_mask_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (kind_i)
            KIND_DELIVER: begin
              if (lane_refill) begin
                lane_d[lane_idx] = LS_HOLD;
              end
            end
            KIND_END: begin
              if (lane_refill) begin
                lane_d[lane_idx] = LS_DONE;
              end
            end
            KIND_REQUEST: begin
              cnt_d  = '0;
              hold_d = hold_vec;
              priority if (&done_vec) begin
                pend_status_d = ST_EXHAUSTED;
                pend_mask_d   = '0;
                state_d       = S_EMIT;
              end else if (|wait_vec) begin
                pend_status_d = ST_WAITING;
                pend_mask_d   = wait_vec;
                state_d       = S_EMIT;
              end else begin
                pend_status_d = ST_RECORD;
                pend_mask_d   = '0;
                state_d       = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_issue) begin
          cnt_d  = cnt_q + CNT_W'(1);
          hold_d = hold_q >> 1;
        end
        if (scan_end) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = pend_status_q;
          if (pend_status_q == ST_RECORD) begin
            out_key_d   = best_key;
            out_value_d = best_value;
            out_mask_d  = best_mask;
            for (int i = 0; i < LANES; i++) begin
              if (best_mask[i]) begin
                lane_d[i] = LS_REFILL;
              end
            end
          end else begin
            out_key_d   = '0;
            out_value_d = '0;
            out_mask_d  = pend_mask_q;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        lane_q[i] <= LS_REFILL;
      end
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      lane_q      <= lane_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q         <= cnt_d;
    hold_q        <= hold_d;
    rd_hold_q     <= rd_hold_d;
    rd_lane_q     <= rd_lane_d;
    pend_status_q <= pend_status_d;
    pend_mask_q   <= pend_mask_d;
    out_status_q  <= out_status_d;
    out_key_q     <= out_key_d;
    out_value_q   <= out_value_d;
    out_mask_q    <= out_mask_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign out_key_o     = FIELD_W'(out_key_q);
  assign out_value_o   = FIELD_W'(out_value_q);
  assign refill_mask_o = MASK_W'(out_mask_q);

  `DKM_ASSERT_NEXT(a_request_leaves_idle, in_acc && (kind_i == KIND_REQUEST), state_q != S_IDLE)
  `DKM_ASSERT_SAME(a_scan_count_bound, state_q == S_SCAN, int'(cnt_q) <= LANES)
  `DKM_ASSERT_NEXT(a_emit_loads_output, (state_q == S_EMIT) && out_free, out_valid_q)
  `DKM_ASSERT_SAME(a_record_releases_lane,
                   out_valid_q && (out_status_q == ST_RECORD), out_mask_q != '0)

endmodule

`default_nettype wire
